// File: rtl/core/dmd_pkg.sv
// Shared types and constants for the delimited message deframer.
// No dependencies; used by dmd_window, dmd_skid and the core top level.
package dmd_pkg;

    // widths fixed by the stream and the register map
    localparam int DATA_W         = 8;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_LEN_W      = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int DELIM_REG_BYTES = 4;

    // default window depth (longest delimiter held)
    localparam int MAX_DELIM_LEN_DEF = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 1'b1;

    // register reset values: two-byte delimiter, CR then LF
    localparam logic [CFG_LEN_W-1:0]  CFG_LEN_RESET   = 3'd2;
    localparam logic [CFG_DATA_W-1:0] CFG_BYTES_RESET = 32'h0000_0A0D;

    // one output request
    typedef struct packed {
        logic [DATA_W-1:0] message_byte;
        logic              byte_valid;
        logic              end_of_message;
    } dmd_result_t;

endpackage

// File: rtl/core/dmd_window.sv
// Match window and fill count, with the combinational step logic that
// compares, shifts and forms the result. Depends on dmd_pkg.
module dmd_window #(
    parameter int MAX_DELIM_LEN = dmd_pkg::MAX_DELIM_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [dmd_pkg::DATA_W-1:0]          data_byte,
    input  logic [dmd_pkg::CFG_LEN_W-1:0]       delim_len,
    input  logic [dmd_pkg::CFG_DATA_W-1:0]      delim_bytes,
    output logic                                res_valid,
    output dmd_pkg::dmd_result_t                res
);
    import dmd_pkg::*;

    localparam int FILL_W = $clog2(MAX_DELIM_LEN + 1);
    localparam logic [3:0] MAX_L = 4'(MAX_DELIM_LEN);

    logic [MAX_DELIM_LEN-1:0][DATA_W-1:0] window_reg, window_next;
    logic [FILL_W-1:0]                    fill_reg, fill_next;

    logic [MAX_DELIM_LEN-1:0][DATA_W-1:0] delim;
    logic [MAX_DELIM_LEN-1:0][DATA_W-1:0] win_ins;
    logic [MAX_DELIM_LEN-1:0][DATA_W-1:0] win_shift;
    logic [3:0]                           len_wide;
    logic [FILL_W-1:0]                    len;
    logic [FILL_W-1:0]                    fill_inc;
    logic                                 match;

    // delimiter bytes, positions past the register compare against zero
    for (genvar g = 0; g < MAX_DELIM_LEN; g++)
    begin : g_delim
        if (g < DELIM_REG_BYTES)
        begin : g_reg
            assign delim[g] = delim_bytes[DATA_W*g +: DATA_W];
        end
        else
        begin : g_zero
            assign delim[g] = '0;
        end
    end

    // effective length, clamped to one .. window depth
    always_comb
    begin
        len_wide = {1'b0, delim_len};
        if (len_wide == 4'd0)
            len_wide = 4'd1;
        if (len_wide > MAX_L)
            len_wide = MAX_L;
        len = FILL_W'(len_wide);
    end

    assign fill_inc = fill_reg + FILL_W'(1);

    // window with the new byte written at the fill position
    always_comb
    begin
        for (int i = 0; i < MAX_DELIM_LEN; i++)
            win_ins[i] = (FILL_W'(i) == fill_reg) ? data_byte : window_reg[i];
    end

    // oldest byte dropped, new byte lands at the last held place
    always_comb
    begin
        for (int i = 0; i < MAX_DELIM_LEN - 1; i++)
            win_shift[i] = (FILL_W'(i + 1) == fill_reg) ? data_byte : window_reg[i + 1];
        win_shift[MAX_DELIM_LEN-1] =
            (FILL_W'(MAX_DELIM_LEN) == fill_reg) ? data_byte : '0;
    end

    // compare the leading len bytes against the delimiter
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < MAX_DELIM_LEN; i++)
            if ((FILL_W'(i) < len) && (win_ins[i] != delim[i]))
                match = 1'b0;
    end

    // step decision
    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (step)
        begin
            if (fill_reg >= len)
            begin
                // stale window after a shorter length: drain one byte
                window_next      = win_shift;
                res_valid        = 1'b1;
                res.message_byte = win_ins[0];
                res.byte_valid   = 1'b1;
            end
            else if (fill_inc < len)
            begin
                window_next = win_ins;
                fill_next   = fill_inc;
            end
            else if (match)
            begin
                window_next        = '0;
                fill_next          = '0;
                res_valid          = 1'b1;
                res.end_of_message = 1'b1;
            end
            else
            begin
                window_next      = win_shift;
                res_valid        = 1'b1;
                res.message_byte = win_ins[0];
                res.byte_valid   = 1'b1;
            end
        end
    end

    // window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: rtl/core/dmd_skid.sv
// Two-entry result buffer between the step logic and the output channel.
// Depends on dmd_pkg for the result type.
module dmd_skid (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dmd_pkg::dmd_result_t  push_data,
    input  logic                  pop,
    output logic                  head_valid,
    output dmd_pkg::dmd_result_t  head_data,
    output logic                  full
);
    import dmd_pkg::*;

    dmd_result_t slot0_reg, slot0_next;
    dmd_result_t slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;

    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot0_reg;
    assign full       = (count_reg == 2'd2);

    // slot movement
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push && pop)
        begin
            if (count_reg == 2'd1)
                slot0_next = push_data;
            else
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                slot0_next = push_data;
            else
                slot1_next = push_data;
            count_next = count_reg + 2'd1;
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// File: rtl/core/delimited_message_deframer_core.sv
// Top level of the delimited message deframer: configuration registers,
// match window and result buffer. Depends on dmd_pkg, dmd_window, dmd_skid.
//
//  channel   | valid / stall          | payload
//  ----------+------------------------+------------------------------------------
//  input     | data_valid / data_stall| data_byte
//  output    | msg_valid / msg_stall  | message_byte, byte_valid, end_of_message
//  config    | cfg_write_enable       | cfg_index, cfg_write_data
//
// One input byte is taken per cycle while data_stall is low. Its result, if any, is
// formed in the accepting cycle and shown on the output the following cycle when the
// buffer is empty. The one register stage on this path is the result buffer; an older
// request still waiting in the buffer delays the result further.
// Reset clears the window, the buffer and loads CR LF as delimiter.
// data_stall rises only when both buffer entries hold undelivered requests.
module delimited_message_deframer_core #(
    parameter int MAX_DELIM_LEN = dmd_pkg::MAX_DELIM_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              data_valid,
    output logic                              data_stall,
    input  logic [dmd_pkg::DATA_W-1:0]        data_byte,
    output logic                              msg_valid,
    input  logic                              msg_stall,
    output logic [dmd_pkg::DATA_W-1:0]        message_byte,
    output logic                              byte_valid,
    output logic                              end_of_message,
    input  logic                              cfg_write_enable,
    input  logic [dmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmd_pkg::CFG_DATA_W-1:0]    cfg_write_data
);
    import dmd_pkg::*;

    logic [CFG_LEN_W-1:0]  delim_len_reg;
    logic [CFG_DATA_W-1:0] delim_bytes_reg;
    logic                  accept;
    logic                  res_valid;
    dmd_result_t           res;
    dmd_result_t           head;
    logic                  buf_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_len_reg   <= CFG_LEN_RESET;
            delim_bytes_reg <= CFG_BYTES_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                CFG_DELIM_LENGTH: delim_len_reg   <= cfg_write_data[CFG_LEN_W-1:0];
                CFG_DELIM_BYTES:  delim_bytes_reg <= cfg_write_data;
                default: ;
            endcase
        end
    end

    // input handshake
    assign data_stall = buf_full;
    assign accept     = data_valid && !buf_full;

    // window step
    dmd_window #(
        .MAX_DELIM_LEN (MAX_DELIM_LEN)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .data_byte   (data_byte),
        .delim_len   (delim_len_reg),
        .delim_bytes (delim_bytes_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result buffer
    dmd_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop        (msg_valid && !msg_stall),
        .head_valid (msg_valid),
        .head_data  (head),
        .full       (buf_full)
    );

    // output payload
    assign message_byte   = head.message_byte;
    assign byte_valid     = head.byte_valid;
    assign end_of_message = head.end_of_message;

endmodule

// File: bench/deframe_checker.sv
`timescale 1ns / 100ps
// Checker for the delimited message deframer: watches the byte, result and register ports,
// predicts each result from its own copy of the window and registers, and compares.
// Depends on dmd_pkg for widths, register indexes and the result layout.
module deframe_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           data_valid,
    input  logic                           data_stall,
    input  logic [dmd_pkg::DATA_W-1:0]     data_byte,
    input  logic                           msg_valid,
    input  logic                           msg_stall,
    input  logic [dmd_pkg::DATA_W-1:0]     message_byte,
    input  logic                           byte_valid,
    input  logic                           end_of_message,
    input  logic                           cfg_write_enable,
    input  logic [dmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmd_pkg::CFG_DATA_W-1:0] cfg_write_data,
    output int                             mismatches,
    output int                             results_due
);
    import dmd_pkg::*;

    localparam int WIN_DEPTH = MAX_DELIM_LEN_DEF;

    // predicted state: window of newest bytes and the two registers
    logic [DATA_W-1:0]     window_q [WIN_DEPTH];
    int unsigned           held;
    logic [CFG_LEN_W-1:0]  delim_len_q;
    logic [CFG_DATA_W-1:0] delim_q;
    dmd_result_t           frames_due [$];
    int                    fail_tally;

    // length register clamped into 1..window depth
    function automatic int unsigned active_length();
        if (delim_len_q == '0)
            return 1;
        if (delim_len_q > WIN_DEPTH)
            return WIN_DEPTH;
        return 32'(delim_len_q);
    endfunction

    // pull the oldest byte out of the window
    function automatic logic [DATA_W-1:0] take_oldest();
        logic [DATA_W-1:0] first;
        first = window_q[0];
        for (int i = 0; i < WIN_DEPTH - 1; i++)
            window_q[i] = window_q[i + 1];
        window_q[WIN_DEPTH - 1] = '0;
        if (held != 0)
            held--;
        return first;
    endfunction

    // one byte into the window; returns 1 when it yields a request
    function automatic bit deframe_byte(input logic [DATA_W-1:0] b, output dmd_result_t r);
        int unsigned n;
        bit          hit;
        n = active_length();
        r = '0;
        // window left over from a longer delimiter: pass oldest, no compare
        if (held >= n)
        begin
            r.message_byte = take_oldest();
            r.byte_valid   = 1'b1;
            window_q[held] = b;
            held++;
            return 1'b1;
        end
        window_q[held] = b;
        held++;
        if (held < n)
            return 1'b0;
        hit = 1'b1;
        for (int i = 0; i < n; i++)
            if (window_q[i] != delim_q[8*i +: 8])
                hit = 1'b0;
        if (hit)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
                window_q[i] = '0;
            held = 0;
            r.end_of_message = 1'b1;
            return 1'b1;
        end
        r.message_byte = take_oldest();
        r.byte_valid   = 1'b1;
        return 1'b1;
    endfunction

    // follow the ports, predict on each accepted byte, compare each delivered request
    always @(posedge clk or negedge rst_n)
    begin
        dmd_result_t due;
        dmd_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
                window_q[i] = '0;
            held        = 0;
            delim_len_q = CFG_LEN_RESET;
            delim_q     = CFG_BYTES_RESET;
            frames_due.delete();
            fail_tally  = 0;
            mismatches  <= 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    CFG_DELIM_LENGTH: delim_len_q = cfg_write_data[CFG_LEN_W-1:0];
                    CFG_DELIM_BYTES:  delim_q     = cfg_write_data;
                    default: ;
                endcase
            end
            if (data_valid && !data_stall)
            begin
                if (deframe_byte(data_byte, due))
                    frames_due.push_back(due);
            end
            if (msg_valid && !msg_stall)
            begin
                got.message_byte   = message_byte;
                got.byte_valid     = byte_valid;
                got.end_of_message = end_of_message;
                if (frames_due.size() == 0)
                begin
                    $error("request with none expected: message_byte %0h byte_valid %0b eom %0b",
                           got.message_byte, got.byte_valid, got.end_of_message);
                    fail_tally++;
                end
                else
                begin
                    due = frames_due.pop_front();
                    if (got.message_byte !== due.message_byte)
                    begin
                        $error("message_byte: expected %0h, actual %0h",
                               due.message_byte, got.message_byte);
                        fail_tally++;
                    end
                    if (got.byte_valid !== due.byte_valid)
                    begin
                        $error("byte_valid: expected %0b, actual %0b",
                               due.byte_valid, got.byte_valid);
                        fail_tally++;
                    end
                    if (got.end_of_message !== due.end_of_message)
                    begin
                        $error("end_of_message: expected %0b, actual %0b",
                               due.end_of_message, got.end_of_message);
                        fail_tally++;
                    end
                end
            end
            mismatches  <= fail_tally;
            results_due <= frames_due.size();
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Top of the deframer bench: clock, reset, byte stimulus, register writes and sink stalls.
// Depends on dmd_pkg, delimited_message_deframer_core and deframe_checker.
module tb;
    import dmd_pkg::*;

    localparam int          ITEM_TARGET   = 1100;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          TAIL_CYCLES   = 16;
    localparam logic [7:0]  CR            = 8'h0D;
    localparam logic [7:0]  LF            = 8'h0A;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  data_valid;
    logic                  data_stall;
    logic [DATA_W-1:0]     data_byte;
    logic                  msg_valid;
    logic                  msg_stall;
    logic [DATA_W-1:0]     message_byte;
    logic                  byte_valid;
    logic                  end_of_message;
    logic                  cfg_write_enable;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_write_data;
    int                    mismatches;
    int                    results_due;

    // stimulus shaping state: delimiter as last written, idle modes
    int unsigned           sent;
    int unsigned           delim_span = 2;
    logic [CFG_DATA_W-1:0] delim_now  = CFG_BYTES_RESET;
    bit                    calm_src;
    bit                    calm_sink;
    int unsigned           hold_left;

    delimited_message_deframer_core DUT (.*);

    deframe_checker u_checker (.*);

    always #4 clk = ~clk;

    // cycles to wait before a request; none during calm stretches
    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // content byte, often one of the delimiter bytes to provoke near misses
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 2) == 0)
            return delim_now[8*$urandom_range(0, delim_span - 1) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    // sink: random stall drawn after every delivered request; none during calm stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_stall <= 1'b0;
            hold_left = 0;
        end
        else if (msg_valid && !msg_stall)
        begin
            hold_left = draw_wait(calm_sink);
            msg_stall <= (hold_left != 0);
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            msg_stall <= (hold_left != 0);
        end
    end

    // one byte request, held until accepted
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_wait(calm_src);
        if (gap != 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        sent++;
    endtask

    // drain all outstanding requests; allow for a byte still in the window stage
    task automatic settle();
        data_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_write_data   <= val;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    // new delimiter, written only once the block is idle
    task automatic set_delimiter(input logic [CFG_LEN_W-1:0] len, input logic [CFG_DATA_W-1:0] bytes);
        settle();
        write_reg(CFG_DELIM_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_DELIM_BYTES, bytes);
        delim_now  = bytes;
        delim_span = (len == 0) ? 1 : (len > MAX_DELIM_LEN_DEF) ? MAX_DELIM_LEN_DEF : len;
    endtask

    // message body then the delimiter, sometimes cut short
    task automatic send_message();
        int unsigned body;
        int unsigned cut;
        body = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
        for (int k = 0; k < body; k++)
            send_byte(pick_byte());
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, delim_span - 1) : delim_span;
        for (int k = 0; k < cut; k++)
            send_byte(delim_now[8*k +: 8]);
    endtask

    // hard limit on run time
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] bytes;
        rst_n            <= 1'b0;
        data_valid       <= 1'b0;
        data_byte        <= '0;
        cfg_write_enable <= 1'b0;
        cfg_index        <= CFG_DELIM_LENGTH;
        cfg_write_data   <= '0;
        sent      = 0;
        calm_src  = 1'b0;
        calm_sink = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset delimiter: plain content, empty message, CR before CR LF, zero byte
        send_byte("a");
        send_byte(8'hFF);
        send_byte(CR);
        send_byte(LF);
        send_byte(CR);
        send_byte(LF);
        send_byte(8'h00);
        send_byte(CR);
        send_byte(CR);
        send_byte(LF);

        // partial window, then a shorter delimiter: length zero acts as one, stale window drains
        send_byte("A");
        set_delimiter(3'd0, 32'h0000_0000);
        send_byte(8'h00);
        send_byte(8'h55);

        // length above the window acts as four; zero bytes inside the delimiter
        set_delimiter(3'd7, 32'h00FF_0D00);
        send_byte(8'h00);
        send_byte(CR);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(CR);
        send_byte(8'hFF);
        send_byte(8'h00);

        // all-ones delimiter of three bytes
        set_delimiter(3'd3, 32'hFFFF_FFFF);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);

        // random phases: new delimiter and idle mode, mostly framed messages, some noise
        while (sent < ITEM_TARGET)
        begin
            calm_src  = ($urandom_range(0, 3) == 0);
            calm_sink = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       bytes = {4{8'($urandom_range(0, 255))}};
                1:       bytes = $urandom() & {{8{$urandom_range(0, 1) == 1}},
                                               {8{$urandom_range(0, 1) == 1}},
                                               {8{$urandom_range(0, 1) == 1}},
                                               {8{$urandom_range(0, 1) == 1}}};
                default: bytes = $urandom();
            endcase
            set_delimiter(3'($urandom_range(0, 7)), bytes);
            repeat ($urandom_range(6, 20))
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom_range(0, 255)));
                end
                else
                    send_message();
            end
        end

        // wait for the last requests, then a quiet tail
        data_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
